>>> rtl/text_console_char_writer_top_macros.svh
// assertion macros for the text console writer checker
// depends on clk and rst being visible where a macro is used
`ifndef TEXT_CONSOLE_CHAR_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_TOP_MACROS_SVH

// checked outside reset only
`define TCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define TCW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/tcw_pkg.sv
// types and constants of the text console writer
// no dependencies
package tcw_pkg;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BLANK     = 8'd32;

  localparam logic [7:0] ATTR_RESET = 8'h07;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_column;
  } tcw_request_t;

  typedef struct packed {
    logic [6:0] cursor_column;
    logic [4:0] cursor_row;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic       scrolled;
  } tcw_response_t;

endpackage

>>> rtl/tcw_stream_if.sv
// valid/ready channel with a typed payload
// depends on nothing; payload type given at instantiation
interface tcw_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/tcw_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/text_console_char_writer_top.sv
// text console engine: cell store in one ram, cursor and command sequencer
// depends on tcw_pkg, tcw_stream_if and tcw_ram
//
//   channel   dir  payload          transaction
//   request   in   tcw_request_t    valid & ready
//   response  out  tcw_response_t   valid & ready
//   cfg       in   attribute byte   valid & ready, always ready
//
// one request at a time, from accept to result register: put passes exec and finish,
// read exec, read and finish (exec and finish when out of range), unused command exec
// and finish; clear: exec, then one ram write per cell, then finish
// a scroll adds a pass moving each cell below the top row one row up, one move per cycle through
// the ram read port, then one blank write per bottom cell
// a new request is taken while the previous result waits in the output register
// reset homes the cursor and sets the attribute to 7; cells are undefined until cleared
module text_console_char_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic          clk,
  input logic          rst,
  tcw_stream_if.sink   request,
  tcw_stream_if.source response,
  tcw_stream_if.sink   cfg
);
  import tcw_pkg::*;

  localparam int CW        = $clog2(COLUMNS);
  localparam int RW        = $clog2(ROWS);
  localparam int DEPTH     = ROWS * COLUMNS;
  localparam int AW        = $clog2(DEPTH);
  localparam int LAST_MOVE = (ROWS - 1) * COLUMNS - 1;
  localparam int BOTTOM    = (ROWS - 1) * COLUMNS;
  localparam int LAST_CELL = DEPTH - 1;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_EXEC   = 7'b0000010,
    ST_READ   = 7'b0000100,
    ST_SCROLL = 7'b0001000,
    ST_BLANK  = 7'b0010000,
    ST_CLEAR  = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  state_t        state;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [7:0]    attr;
  tcw_request_t  req_q;
  logic [AW-1:0] scan;
  logic          mv_valid;
  logic [AW-1:0] mv_addr;
  tcw_response_t res;
  logic          out_valid;
  tcw_response_t out_data;
  logic          out_load;

  // put evaluation
  logic [CW:0]   col_next;
  logic [RW:0]   row_next;
  logic          put_we;
  logic [7:0]    put_char;
  logic [CW-1:0] put_col;
  logic          need_scroll;
  logic [AW-1:0] put_addr;
  logic [AW-1:0] read_addr;
  logic          read_ok;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  always_comb begin
    col_next = {1'b0, col};
    row_next = {1'b0, row};
    put_we   = 1'b0;
    put_char = req_q.char_code;
    put_col  = col;
    case (req_q.char_code)
      CH_NEWLINE: begin
        col_next = '0;
        row_next = row_next + 1'b1;
      end
      CH_BACKSPACE: begin
        if (col != '0) begin
          col_next = {1'b0, col} - 1'b1;
          put_we   = 1'b1;
          put_col  = col - 1'b1;
          put_char = CH_BLANK;
        end
      end
      CH_TAB: begin
        col_next = ({1'b0, col} + (CW+1)'(4)) & ~(CW+1)'(3);
      end
      default: begin
        put_we   = 1'b1;
        col_next = {1'b0, col} + 1'b1;
      end
    endcase
    // wrap at the right edge
    if (col_next >= (CW+1)'(COLUMNS)) begin
      col_next = '0;
      row_next = row_next + 1'b1;
    end
    need_scroll = (row_next >= (RW+1)'(ROWS));
  end

  assign put_addr  = AW'(row * COLUMNS) + AW'(put_col);
  assign read_addr = AW'(req_q.read_row * COLUMNS) + AW'(req_q.read_column);
  assign read_ok   = (req_q.read_row < ROWS) && (req_q.read_column < COLUMNS);
  assign out_load  = (state == ST_FINISH) && (!out_valid || response.ready);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan;
    ram_wdata = {attr, CH_BLANK};
    ram_re    = 1'b0;
    ram_raddr = scan + AW'(COLUMNS);
    case (state)
      ST_EXEC: begin
        if (req_q.command == CMD_PUT && put_we) begin
          ram_we    = 1'b1;
          ram_waddr = put_addr;
          ram_wdata = {attr, put_char};
        end
        if (req_q.command == CMD_READ && read_ok) begin
          ram_re    = 1'b1;
          ram_raddr = read_addr;
        end
      end
      ST_SCROLL: begin
        // read one row down, write the previous read one row up
        ram_re = 1'b1;
        if (mv_valid) begin
          ram_we    = 1'b1;
          ram_waddr = mv_addr;
          ram_wdata = ram_rdata;
        end
      end
      ST_BLANK: begin
        ram_we = 1'b1;
        if (mv_valid) begin
          ram_waddr = mv_addr;
          ram_wdata = ram_rdata;
        end
      end
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      col       <= '0;
      row       <= '0;
      attr      <= ATTR_RESET;
      out_valid <= 1'b0;
      mv_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        attr <= cfg.data;
      end
      if (out_load) begin
        out_data  <= res;
        out_valid <= 1'b1;
      end else if (response.ready) begin
        out_valid <= 1'b0;
      end
      mv_valid <= (state == ST_SCROLL);
      mv_addr  <= scan;
      case (state)
        ST_IDLE: begin
          if (request.valid) begin
            req_q <= request.data;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res.cell_char <= '0;
          res.cell_attr <= '0;
          case (req_q.command)
            CMD_PUT: begin
              col               <= CW'(col_next);
              res.cursor_column <= 7'(col_next);
              res.scrolled      <= need_scroll;
              if (need_scroll) begin
                row            <= RW'(ROWS - 1);
                res.cursor_row <= 5'(ROWS - 1);
                scan           <= '0;
                state          <= ST_SCROLL;
              end else begin
                row            <= RW'(row_next);
                res.cursor_row <= 5'(row_next);
                state          <= ST_FINISH;
              end
            end
            CMD_CLEAR: begin
              col               <= '0;
              row               <= '0;
              res.cursor_column <= '0;
              res.cursor_row    <= '0;
              res.scrolled      <= 1'b0;
              scan              <= '0;
              state             <= ST_CLEAR;
            end
            CMD_READ: begin
              res.cursor_column <= 7'(col);
              res.cursor_row    <= 5'(row);
              res.scrolled      <= 1'b0;
              if (read_ok) begin
                state <= ST_READ;
              end else begin
                state <= ST_FINISH;
              end
            end
            default: begin
              res.cursor_column <= 7'(col);
              res.cursor_row    <= 5'(row);
              res.scrolled      <= 1'b0;
              state             <= ST_FINISH;
            end
          endcase
        end
        ST_READ: begin
          res.cell_char <= ram_rdata[7:0];
          res.cell_attr <= ram_rdata[15:8];
          state         <= ST_FINISH;
        end
        ST_SCROLL: begin
          if (scan == AW'(LAST_MOVE)) begin
            scan  <= AW'(BOTTOM);
            state <= ST_BLANK;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        ST_BLANK: begin
          // the first cycle finishes the last move and holds the pointer
          if (!mv_valid) begin
            if (scan == AW'(LAST_CELL)) begin
              state <= ST_FINISH;
            end else begin
              scan <= scan + 1'b1;
            end
          end
        end
        ST_CLEAR: begin
          if (scan == AW'(LAST_CELL)) begin
            state <= ST_FINISH;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign request.ready  = (state == ST_IDLE);
  assign response.valid = out_valid;
  assign response.data  = out_data;
  assign cfg.ready      = 1'b1;

endmodule

>>> rtl/tcw_checker.sv
// port-level checks of the text console writer, bound to the top level
// depends on tcw_pkg and text_console_char_writer_top_macros.svh
`include "text_console_char_writer_top_macros.svh"

module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input tcw_pkg::tcw_response_t rsp_data
);

  logic req_accept;
  assign req_accept = req_valid && req_ready;

  `TCW_ASSERT(a_rsp_valid_holds, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")
  `TCW_ASSERT(a_rsp_data_holds, rsp_valid && !rsp_ready |=> $stable(rsp_data), "response changed while stalled")
  `TCW_ASSERT(a_one_at_a_time, req_accept |=> !req_ready, "request taken while one is in progress")
  `TCW_ASSERT(a_column_bound, rsp_valid |-> rsp_data.cursor_column < COLUMNS, "cursor column out of range")
  `TCW_ASSERT(a_scroll_bottom, rsp_valid && rsp_data.scrolled |-> rsp_data.cursor_row == 5'(ROWS - 1), "scroll left cursor off the bottom row")

endmodule

bind text_console_char_writer_top tcw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcw_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(request.valid),
  .req_ready(request.ready),
  .rsp_valid(response.valid),
  .rsp_ready(response.ready),
  .rsp_data (response.data)
);
